[sv/iil_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer and identifier lexer package
// Shared widths, token codes, mode and step types, and the microcode ROM.
// ----------------------------------------------------------------------------
package iil_pkg;

    // Identifier buffer sizing.
    localparam int MAX_ID_LEN = 16;
    localparam int LEN_W      = $clog2(MAX_ID_LEN + 1);
    localparam int IDX_W      = $clog2(MAX_ID_LEN);

    // Field widths.
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 3;
    localparam int LINE_W  = 24;
    localparam int VALUE_W = 31;
    localparam int DATA_W  = 64;

    localparam logic [LINE_W-1:0]  LINE_MAX  = {LINE_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // Characters of interest.
    localparam logic [CHAR_W-1:0] CH_EOT   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    // Keyword spelling.
    localparam int KW_LEN = 5;

    // Token kinds as carried on the result channel.
    localparam logic [KIND_W-1:0] KIND_ERROR = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IDENT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WHILE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EOT   = 3'd4;

    // Scan mode between input bytes.
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_NUM   = 4'b0010,
        MODE_IDENT = 4'b0100,
        MODE_DONE  = 4'b1000
    } mode_t;

    // Microprogram step addresses.
    typedef enum logic [3:0] {
        S_FETCH     = 4'd0,
        S_DISPATCH  = 4'd1,
        S_NUM_ACC   = 4'd2,
        S_ERR_TOK   = 4'd3,
        S_INT_OUT   = 4'd4,
        S_ID_STORE  = 4'd5,
        S_ID_OUT    = 4'd6,
        S_WHILE_OUT = 4'd7,
        S_EOT       = 4'd8,
        S_LINE      = 4'd9,
        S_START_NUM = 4'd10,
        S_START_ID  = 4'd11,
        S_ERR_CUR   = 4'd12
    } step_t;

    // Result word produced by a step.
    typedef enum logic [2:0] {
        E_NONE,
        E_ERR_TOK,
        E_ERR_CUR,
        E_INT,
        E_CHAR,
        E_WHILE,
        E_EOT
    } emit_t;

    // Datapath operation of a step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCUM,
        OP_STORE,
        OP_CLR_NUM,
        OP_CHAR_NEXT,
        OP_CLR_IDENT,
        OP_SET_DONE,
        OP_LINE_INC,
        OP_START_NUM,
        OP_START_ID
    } op_t;

    // Sequencing of a step.
    typedef enum logic [2:0] {
        J_GOTO,
        J_ACCEPT,
        J_TOKEN,
        J_IDLE,
        J_LAST
    } jump_t;

    typedef struct packed {
        logic  accept;
        emit_t emit;
        op_t   op;
        jump_t jump;
        step_t target;
    } ctrl_word_t;

    // Microcode ROM: one control word per step.
    function automatic ctrl_word_t mc_rom(input step_t step);
        ctrl_word_t w;
        w = '{accept: 1'b0, emit: E_NONE, op: OP_NONE, jump: J_GOTO, target: S_FETCH};
        unique case (step)
            S_FETCH:     begin w.accept = 1'b1; w.jump = J_ACCEPT; w.target = S_DISPATCH; end
            S_DISPATCH:  begin w.jump = J_TOKEN; end
            S_NUM_ACC:   begin w.op = OP_ACCUM; end
            S_ERR_TOK:   begin w.emit = E_ERR_TOK; w.op = OP_SET_DONE; end
            S_INT_OUT:   begin w.emit = E_INT; w.op = OP_CLR_NUM; w.jump = J_IDLE; end
            S_ID_STORE:  begin w.op = OP_STORE; end
            S_ID_OUT:    begin w.emit = E_CHAR; w.op = OP_CHAR_NEXT; w.jump = J_LAST; end
            S_WHILE_OUT: begin w.emit = E_WHILE; w.op = OP_CLR_IDENT; w.jump = J_IDLE; end
            S_EOT:       begin w.emit = E_EOT; w.op = OP_SET_DONE; end
            S_LINE:      begin w.op = OP_LINE_INC; end
            S_START_NUM: begin w.op = OP_START_NUM; end
            S_START_ID:  begin w.op = OP_START_ID; end
            S_ERR_CUR:   begin w.emit = E_ERR_CUR; w.op = OP_SET_DONE; end
            default:     begin w.jump = J_GOTO; end
        endcase
        return w;
    endfunction

    // Letter of the keyword at a given position.
    function automatic logic [CHAR_W-1:0] kw_byte(input logic [2:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            3'd0:    c = 8'h77;  // w
            3'd1:    c = 8'h68;  // h
            3'd2:    c = 8'h69;  // i
            3'd3:    c = 8'h6C;  // l
            3'd4:    c = 8'h65;  // e
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[sv/integer_identifier_lexer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer and identifier lexer
// Scans a byte stream into integer, identifier, keyword, error and end tokens
// under a small microprogram; identifiers are sent one character per word.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word contents
//  s_      | in        | tdata: char_code
//  m_      | out       | tdata: line_number, int_value, ident_char; tuser: kind;
//          |           | tlast: last word of a token
//
//  A byte passes through fetch and dispatch, then an output step for each word of a
//  token that it ends, then one action step unless it is a space or CR or is
//  dropped. An emitting step waits only while the result register still holds
//  an untaken word; the register frees as that word is taken, adding no gap.
//  Reset returns the sequencer to fetch on line one; after an error or end of
//  text every further byte is accepted and dropped until reset.
// ----------------------------------------------------------------------------
module integer_identifier_lexer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [23:0] line_number, [54:24] int_value,
                                   // [62:55] ident_char, [63] zero
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // last_of_token
);

    localparam int LEN_W   = iil_pkg::LEN_W;
    localparam int IDX_W   = iil_pkg::IDX_W;
    localparam int CHAR_W  = iil_pkg::CHAR_W;
    localparam int LINE_W  = iil_pkg::LINE_W;
    localparam int VALUE_W = iil_pkg::VALUE_W;
    localparam int PROD_W  = VALUE_W + 4;

    // Sequencer and datapath registers.
    iil_pkg::step_t          step_reg, step_next;
    iil_pkg::mode_t          mode_reg, mode_next;
    logic [CHAR_W-1:0]       char_reg;
    logic [LINE_W-1:0]       line_reg, line_next;
    logic [LINE_W-1:0]       tok_line_reg, tok_line_next;
    logic [VALUE_W-1:0]      accum_reg, accum_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    kw_match_reg, kw_match_next;
    logic [CHAR_W-1:0]       id_buf [iil_pkg::MAX_ID_LEN];

    // Result register.
    logic                    m_valid_reg;
    logic [63:0]             m_data_reg;
    logic [2:0]              m_user_reg;
    logic                    m_last_reg;

    iil_pkg::ctrl_word_t     cw;
    logic                    out_free;
    logic                    exec;
    logic                    accepted;
    logic                    is_digit, is_lower, is_alpha;
    logic                    id_last;
    logic                    is_while;
    logic [PROD_W-1:0]       prod;
    iil_pkg::step_t          idle_target, token_target;
    logic                    buf_we;
    logic [IDX_W-1:0]        buf_waddr;

    // Control word of the current step.
    assign cw       = iil_pkg::mc_rom(step_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign exec     = (cw.emit == iil_pkg::E_NONE) || out_free;
    assign s_tready = cw.accept;
    assign accepted = s_tvalid && cw.accept;

    // Character classes.
    assign is_digit = (char_reg >= 8'h30) && (char_reg <= 8'h39);
    assign is_lower = (char_reg >= 8'h61) && (char_reg <= 8'h7A);
    assign is_alpha = is_lower || ((char_reg >= 8'h41) && (char_reg <= 8'h5A));

    assign id_last  = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;
    assign is_while = kw_match_reg && (len_reg == LEN_W'(iil_pkg::KW_LEN));

    // Decimal accumulate: value times ten plus the digit.
    assign prod = (PROD_W'(accum_reg) << 3) + (PROD_W'(accum_reg) << 1)
                + PROD_W'(char_reg[3:0]);

    // Dispatch for a byte seen between tokens.
    always_comb begin
        priority if (char_reg == iil_pkg::CH_EOT) begin
            idle_target = iil_pkg::S_EOT;
        end else if (char_reg == iil_pkg::CH_SPACE || char_reg == iil_pkg::CH_CR) begin
            idle_target = iil_pkg::S_FETCH;
        end else if (char_reg == iil_pkg::CH_LF) begin
            idle_target = iil_pkg::S_LINE;
        end else if (is_digit) begin
            idle_target = iil_pkg::S_START_NUM;
        end else if (is_lower) begin
            idle_target = iil_pkg::S_START_ID;
        end else begin
            idle_target = iil_pkg::S_ERR_CUR;
        end
    end

    // Dispatch on scan mode and the new byte.
    always_comb begin
        token_target = idle_target;
        unique case (mode_reg)
            iil_pkg::MODE_DONE: begin
                token_target = iil_pkg::S_FETCH;
            end
            iil_pkg::MODE_NUM: begin
                priority if (is_digit)      token_target = iil_pkg::S_NUM_ACC;
                else if (is_alpha)          token_target = iil_pkg::S_ERR_TOK;
                else                        token_target = iil_pkg::S_INT_OUT;
            end
            iil_pkg::MODE_IDENT: begin
                priority if (is_alpha) begin
                    token_target = (len_reg >= LEN_W'(iil_pkg::MAX_ID_LEN))
                                 ? iil_pkg::S_ERR_TOK : iil_pkg::S_ID_STORE;
                end else if (is_digit) begin
                    token_target = iil_pkg::S_ERR_TOK;
                end else begin
                    token_target = is_while ? iil_pkg::S_WHILE_OUT : iil_pkg::S_ID_OUT;
                end
            end
            iil_pkg::MODE_IDLE: begin
                token_target = idle_target;
            end
            default: begin
                token_target = iil_pkg::S_FETCH;
            end
        endcase
    end

    // Step sequencing.
    always_comb begin
        step_next = step_reg;
        if (exec) begin
            unique case (cw.jump)
                iil_pkg::J_GOTO:   step_next = cw.target;
                iil_pkg::J_ACCEPT: step_next = accepted ? cw.target : step_reg;
                iil_pkg::J_TOKEN:  step_next = token_target;
                iil_pkg::J_IDLE:   step_next = idle_target;
                iil_pkg::J_LAST:   step_next = id_last ? idle_target : step_reg;
                default:           step_next = iil_pkg::S_FETCH;
            endcase
        end
    end

    // Datapath operations.
    always_comb begin
        mode_next     = mode_reg;
        line_next     = line_reg;
        tok_line_next = tok_line_reg;
        accum_next    = accum_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        kw_match_next = kw_match_reg;
        buf_we        = 1'b0;
        buf_waddr     = len_reg[IDX_W-1:0];
        if (exec) begin
            unique case (cw.op)
                iil_pkg::OP_NONE: begin
                end
                iil_pkg::OP_ACCUM: begin
                    accum_next = (prod > PROD_W'(iil_pkg::VALUE_MAX))
                               ? iil_pkg::VALUE_MAX : prod[VALUE_W-1:0];
                end
                iil_pkg::OP_STORE: begin
                    buf_we        = 1'b1;
                    len_next      = len_reg + LEN_W'(1);
                    kw_match_next = kw_match_reg
                                 && (len_reg < LEN_W'(iil_pkg::KW_LEN))
                                 && (char_reg == iil_pkg::kw_byte(len_reg[2:0]));
                end
                iil_pkg::OP_CLR_NUM: begin
                    accum_next = '0;
                    mode_next  = iil_pkg::MODE_IDLE;
                end
                iil_pkg::OP_CHAR_NEXT: begin
                    if (id_last) begin
                        idx_next  = '0;
                        len_next  = '0;
                        mode_next = iil_pkg::MODE_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                iil_pkg::OP_CLR_IDENT: begin
                    len_next  = '0;
                    idx_next  = '0;
                    mode_next = iil_pkg::MODE_IDLE;
                end
                iil_pkg::OP_SET_DONE: begin
                    mode_next = iil_pkg::MODE_DONE;
                end
                iil_pkg::OP_LINE_INC: begin
                    if (line_reg != iil_pkg::LINE_MAX) line_next = line_reg + LINE_W'(1);
                end
                iil_pkg::OP_START_NUM: begin
                    mode_next     = iil_pkg::MODE_NUM;
                    tok_line_next = line_reg;
                    accum_next    = VALUE_W'(char_reg[3:0]);
                end
                iil_pkg::OP_START_ID: begin
                    mode_next     = iil_pkg::MODE_IDENT;
                    tok_line_next = line_reg;
                    buf_we        = 1'b1;
                    buf_waddr     = '0;
                    len_next      = LEN_W'(1);
                    idx_next      = '0;
                    kw_match_next = (char_reg == iil_pkg::kw_byte(3'd0));
                end
                default: begin
                end
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= iil_pkg::S_FETCH;
            mode_reg     <= iil_pkg::MODE_IDLE;
            line_reg     <= LINE_W'(1);
            tok_line_reg <= LINE_W'(1);
            accum_reg    <= '0;
            len_reg      <= '0;
            idx_reg      <= '0;
            kw_match_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            tok_line_reg <= tok_line_next;
            accum_reg    <= accum_next;
            len_reg      <= len_next;
            idx_reg      <= idx_next;
            kw_match_reg <= kw_match_next;
        end
    end

    // Input byte capture.
    always_ff @(posedge aclk) begin
        if (accepted) char_reg <= s_tdata;
    end

    // Identifier buffer.
    always_ff @(posedge aclk) begin
        if (buf_we) id_buf[buf_waddr] <= char_reg;
    end

    // Result register: loaded by an emitting step when the slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec && cw.emit != iil_pkg::E_NONE) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec && cw.emit != iil_pkg::E_NONE) begin
            m_last_reg <= (cw.emit == iil_pkg::E_CHAR) ? id_last : 1'b1;
            unique case (cw.emit)
                iil_pkg::E_ERR_TOK: begin
                    m_user_reg <= iil_pkg::KIND_ERROR;
                    m_data_reg <= {1'b0, 8'h00, 31'd0, tok_line_reg};
                end
                iil_pkg::E_ERR_CUR: begin
                    m_user_reg <= iil_pkg::KIND_ERROR;
                    m_data_reg <= {1'b0, 8'h00, 31'd0, line_reg};
                end
                iil_pkg::E_INT: begin
                    m_user_reg <= iil_pkg::KIND_INT;
                    m_data_reg <= {1'b0, 8'h00, accum_reg, tok_line_reg};
                end
                iil_pkg::E_CHAR: begin
                    m_user_reg <= iil_pkg::KIND_IDENT;
                    m_data_reg <= {1'b0, id_buf[idx_reg], 31'd0, tok_line_reg};
                end
                iil_pkg::E_WHILE: begin
                    m_user_reg <= iil_pkg::KIND_WHILE;
                    m_data_reg <= {1'b0, 8'h00, 31'd0, tok_line_reg};
                end
                iil_pkg::E_EOT: begin
                    m_user_reg <= iil_pkg::KIND_EOT;
                    m_data_reg <= {1'b0, 8'h00, 31'd0, line_reg};
                end
                default: begin
                    m_user_reg <= iil_pkg::KIND_ERROR;
                    m_data_reg <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // Once finished, no new word is ever loaded.
    a_silent_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == iil_pkg::MODE_DONE && !m_valid_reg) |=> !m_valid_reg)
        else $error("result word produced after error or end of text");

    // The held identifier never exceeds the buffer.
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(iil_pkg::MAX_ID_LEN))
        else $error("identifier length beyond buffer depth");

    // Character emission only reads entries written for this identifier.
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == iil_pkg::S_ID_OUT) |-> (LEN_W'(idx_reg) < len_reg))
        else $error("identifier read index past stored length");

    // An accepted byte is always dispatched next.
    a_fetch_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (step_reg == iil_pkg::S_DISPATCH))
        else $error("accepted byte not dispatched");
`endif

endmodule
